>>> hw/rtl/bgra_to_nv12_converter_assert.svh
// Assertion macros shared by the converter's checker.
`ifndef BGRA_TO_NV12_CONVERTER_ASSERT_SVH
`define BGRA_TO_NV12_CONVERTER_ASSERT_SVH

// Require cons in the same cycle as ante.
`define BN12_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Require cons in the cycle after ante.
`define BN12_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/bn12_pkg.sv
// Types, constants and width helpers shared by the converter's modules.
package bn12_pkg;

  // Default for the widest frame the line store covers
  localparam int MAX_WIDTH_DEFAULT = 4096;

  // Configuration register port
  localparam int CFG_W       = 13;
  localparam int REG_INDEX_W = 1;
  localparam logic [REG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [REG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'd1;
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 13'd1920;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 13'd1080;

  // Frame size limits and row counter width
  localparam int MIN_SIZE   = 2;
  localparam int MAX_HEIGHT = 4096;
  localparam int ROW_W      = 12;

  // Queue depths
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    logic [7:0] luma;
    logic       chroma_valid;
    logic [7:0] chroma_u;
    logic [7:0] chroma_v;
    logic       frame_end;
  } result_t;

  // Position class of a pixel
  typedef struct packed {
    logic odd_col;
    logic odd_row;
    logic frame_end;
  } pix_class_t;

  // Item passed from front to back (pair index travels beside it)
  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] u;
    logic [7:0] v;
    pix_class_t cls;
  } mid_t;

  // Width of the effective frame width
  function automatic int width_bits(input int max_width);
    int w;
    w = $clog2(max_width + 1);
    return (w > CFG_W) ? w : CFG_W;
  endfunction

  // Entries of the line store
  function automatic int line_depth(input int max_width);
    return (max_width + 1) / 2;
  endfunction

  // Address bits of the line store
  function automatic int index_bits(input int max_width);
    int d;
    d = (max_width + 1) / 2;
    return (d > 1) ? $clog2(d) : 1;
  endfunction

endpackage

>>> hw/rtl/bn12_ram.sv
// Generic simple dual-port RAM with registered read.
module bn12_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/bn12_fifo.sv
// Small synchronous queue with occupancy count.
module bn12_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty,
  output logic [CW-1:0]    count
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic             do_push, do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

>>> hw/rtl/bn12_front.sv
// Front end: accepts pixels, tracks position and computes Y, U and V per pixel.
module bn12_front import bn12_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT,
  localparam int EW    = width_bits(MAX_WIDTH),
  localparam int IDX_W = index_bits(MAX_WIDTH),
  localparam int MID_W = $bits(mid_t) + IDX_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  pixel_t           pixel,
  input  logic [EW-1:0]    width_eff,
  input  logic [CFG_W-1:0] height_eff,
  output logic             mid_push,
  output logic [MID_W-1:0] mid_data,
  input  logic             mid_full
);

  localparam int CW = $clog2(MAX_WIDTH);

  // BT.601 limited-range weights
  localparam logic [16:0] K_YR = 17'd66;
  localparam logic [16:0] K_YG = 17'd129;
  localparam logic [16:0] K_YB = 17'd25;
  localparam logic [16:0] Y_ROUND = 17'd128;
  localparam logic [8:0]  Y_OFFSET = 9'd16;
  localparam logic [17:0] K_UR = 18'd38;
  localparam logic [17:0] K_UG = 18'd74;
  localparam logic [17:0] K_UB = 18'd112;
  localparam logic [17:0] K_VR = 18'd112;
  localparam logic [17:0] K_VG = 18'd94;
  localparam logic [17:0] K_VB = 18'd18;
  // Rounding plus the 128 offset ahead of the shift
  localparam logic [17:0] C_BIAS = 18'd32896;

  logic [CW-1:0]    column_count, column_count_next;
  logic [ROW_W-1:0] row_count, row_count_next;
  logic             accept, row_last, frame_last;
  logic [16:0]      y_acc;
  logic [8:0]       y_sum;
  logic [17:0]      u_acc, v_acc;
  mid_t             item;
  logic [IDX_W-1:0] pair_index;

  assign accept     = push && !mid_full;
  assign row_last   = (EW'(column_count) + EW'(1)) >= width_eff;
  assign frame_last = (CFG_W'(row_count) + CFG_W'(1)) >= height_eff;

  // Next position: wrap the column at row end, the row at frame end
  always_comb begin
    column_count_next = column_count + CW'(1);
    row_count_next    = row_count;
    if (row_last) begin
      column_count_next = '0;
      row_count_next    = frame_last ? '0 : row_count + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // Per-pixel color transform; U and V accumulators stay non-negative
  always_comb begin
    y_acc = K_YR * 17'(pixel.red) + K_YG * 17'(pixel.green)
          + K_YB * 17'(pixel.blue) + Y_ROUND;
    y_sum = 9'(y_acc[16:8]) + Y_OFFSET;
    u_acc = C_BIAS + K_UB * 18'(pixel.blue)
          - K_UR * 18'(pixel.red) - K_UG * 18'(pixel.green);
    v_acc = C_BIAS + K_VR * 18'(pixel.red)
          - K_VG * 18'(pixel.green) - K_VB * 18'(pixel.blue);

    item.luma = y_sum[8] ? 8'hFF : y_sum[7:0];
    item.u    = u_acc[17] ? 8'd0 : u_acc[15:8];
    item.v    = v_acc[17] ? 8'd0 : v_acc[15:8];
    item.cls.odd_col   = column_count[0];
    item.cls.odd_row   = row_count[0];
    item.cls.frame_end = row_last && frame_last;
  end

  assign pair_index = IDX_W'(column_count >> 1);
  assign mid_push   = accept;
  assign mid_data   = {item, pair_index};

endmodule

>>> hw/rtl/bn12_back.sv
// Back end: pairs chroma, runs the line store and averages each 2x2 block.
module bn12_back import bn12_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT,
  localparam int IDX_W = index_bits(MAX_WIDTH),
  localparam int MID_W = $bits(mid_t) + IDX_W,
  localparam int OCW   = $clog2(OUT_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             mid_empty,
  input  logic [MID_W-1:0] mid_data,
  output logic             mid_pop,
  input  logic [OCW-1:0]   out_count,
  output logic             out_push,
  output result_t          out_item
);

  localparam int LINE_DEPTH = line_depth(MAX_WIDTH);

  mid_t             in_item;
  logic [IDX_W-1:0] in_index;
  logic             issue, line_write;
  logic [7:0]       held_u, held_v;
  logic [8:0]       pair_u, pair_v;
  logic [17:0]      line_rdata;
  logic             b1_valid;
  mid_t             b1_item;
  logic [8:0]       b1_pair_u, b1_pair_v;
  logic [9:0]       block_u, block_v;
  logic             block_done;

  assign {in_item, in_index} = mid_data;

  // Take an item only when the output queue has a slot for it
  assign issue   = !mid_empty && ((OCW + 1)'(out_count) + (OCW + 1)'(b1_valid)
                                  < (OCW + 1)'(OUT_DEPTH));
  assign mid_pop = issue;

  // Sum the left and right chroma of a pair
  assign pair_u = 9'(held_u) + 9'(in_item.u);
  assign pair_v = 9'(held_v) + 9'(in_item.v);

  // Hold the left pixel's chroma
  always_ff @(posedge clk) begin
    if (rst) begin
      held_u <= '0;
      held_v <= '0;
    end else if (issue && !in_item.cls.odd_col) begin
      held_u <= in_item.u;
      held_v <= in_item.v;
    end
  end

  // Even rows write pair sums; odd rows read them back through the registered read port
  assign line_write = issue && in_item.cls.odd_col && !in_item.cls.odd_row;

  bn12_ram #(
    .WIDTH (18),
    .DEPTH (LINE_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (line_write),
    .waddr (in_index),
    .wdata ({pair_u, pair_v}),
    .raddr (in_index),
    .rdata (line_rdata)
  );

  // Stage alongside the line store read
  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
    end else begin
      b1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      b1_item   <= in_item;
      b1_pair_u <= pair_u;
      b1_pair_v <= pair_v;
    end
  end

  // Average the block: four values of at most 240 never pass a byte after the shift
  assign block_done = b1_item.cls.odd_col && b1_item.cls.odd_row;
  assign block_u    = 10'(line_rdata[17:9]) + 10'(b1_pair_u);
  assign block_v    = 10'(line_rdata[8:0]) + 10'(b1_pair_v);

  always_comb begin
    out_item.luma         = b1_item.luma;
    out_item.chroma_valid = block_done;
    out_item.chroma_u     = block_done ? block_u[9:2] : 8'd0;
    out_item.chroma_v     = block_done ? block_v[9:2] : 8'd0;
    out_item.frame_end    = b1_item.cls.frame_end;
  end

  assign out_push = b1_valid;

endmodule

>>> hw/rtl/bgra_to_nv12_converter.sv
// Top level of the BGRA to NV12 (BT.601 limited range) pixel converter.
// Pixels enter in raster order through a queue-style push/full port and one result per pixel
// leaves through empty/pop: a luma byte, and on the bottom-right pixel of each 2x2 block the
// averaged U and V. The block sustains one pixel per clock unless a queue is full. The rate is
// set by the line store, a simple dual-port RAM of (MAX_WIDTH+1)/2 entries of 18 bits that each
// pixel touches at most once (write on an even row, registered read on an odd row). The line
// store is not cleared after reset and needs no clearing pass. The user must write frame_width
// and frame_height through write_enable/register_index/write_data only while the converter is
// idle; the block does not enforce it. Out-of-range sizes are clamped to 2..MAX_WIDTH and
// 2..4096. An odd last column or row gets no chroma.
module bgra_to_nv12_converter import bn12_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  pixel_t                 pixel,
  output logic                   empty,
  input  logic                   pop,
  output result_t                result,
  input  logic                   write_enable,
  input  logic [REG_INDEX_W-1:0] register_index,
  input  logic [CFG_W-1:0]       write_data
);

  localparam int EW    = width_bits(MAX_WIDTH);
  localparam int IDX_W = index_bits(MAX_WIDTH);
  localparam int MID_W = $bits(mid_t) + IDX_W;
  localparam int OCW   = $clog2(OUT_DEPTH + 1);

  logic [CFG_W-1:0] frame_width, frame_height;
  logic [EW-1:0]    width_eff;
  logic [CFG_W-1:0] height_eff;
  logic             mid_push, mid_full, mid_empty, mid_pop;
  logic [MID_W-1:0] mid_wdata, mid_rdata;
  logic             out_push;
  result_t          out_item;
  logic [OCW-1:0]   out_count;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (write_enable) begin
      case (register_index)
        REG_FRAME_WIDTH:  frame_width  <= write_data;
        REG_FRAME_HEIGHT: frame_height <= write_data;
        default: ;
      endcase
    end
  end

  // Clamp the frame size to the supported range
  always_comb begin
    if (EW'(frame_width) < EW'(MIN_SIZE)) begin
      width_eff = EW'(MIN_SIZE);
    end else if (EW'(frame_width) > EW'(MAX_WIDTH)) begin
      width_eff = EW'(MAX_WIDTH);
    end else begin
      width_eff = EW'(frame_width);
    end
    if (frame_height < CFG_W'(MIN_SIZE)) begin
      height_eff = CFG_W'(MIN_SIZE);
    end else if (frame_height > CFG_W'(MAX_HEIGHT)) begin
      height_eff = CFG_W'(MAX_HEIGHT);
    end else begin
      height_eff = frame_height;
    end
  end

  bn12_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pixel      (pixel),
    .width_eff  (width_eff),
    .height_eff (height_eff),
    .mid_push   (mid_push),
    .mid_data   (mid_wdata),
    .mid_full   (mid_full)
  );

  // Queue between front and back
  bn12_fifo #(
    .WIDTH (MID_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .wdata (mid_wdata),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty),
    .count ()
  );

  bn12_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .mid_empty (mid_empty),
    .mid_data  (mid_rdata),
    .mid_pop   (mid_pop),
    .out_count (out_count),
    .out_push  (out_push),
    .out_item  (out_item)
  );

  // Result queue facing the consumer
  bn12_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_item),
    .full  (),
    .pop   (pop),
    .rdata (result),
    .empty (empty),
    .count (out_count)
  );

  assign full = mid_full;

endmodule

>>> hw/rtl/bn12_check.sv
// Port-level checker for the converter and its bind to the top level.
`include "bgra_to_nv12_converter_assert.svh"

module bn12_check import bn12_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   push,
  input logic                   full,
  input pixel_t                 pixel,
  input logic                   empty,
  input logic                   pop,
  input result_t                result,
  input logic                   write_enable,
  input logic [REG_INDEX_W-1:0] register_index,
  input logic [CFG_W-1:0]       write_data
);

  // Reset drains both queues
  `BN12_ASSERT_NEXT(a_reset_drains, clk, 1'b0, rst, empty && !full, "queues not drained by reset")

  // A waiting result holds until taken
  `BN12_ASSERT_NEXT(a_result_holds, clk, rst, !empty && !pop, !empty && $stable(result), "result changed while stalled")

  // No chroma without a completed block
  `BN12_ASSERT_SAME(a_chroma_zero, clk, rst, !empty && !result.chroma_valid, result.chroma_u == 8'd0 && result.chroma_v == 8'd0, "chroma set without a block")

  // Luma stays in the limited range
  `BN12_ASSERT_SAME(a_luma_range, clk, rst, !empty, result.luma >= 8'd16 && result.luma <= 8'd235, "luma outside limited range")

endmodule

bind bgra_to_nv12_converter bn12_check u_bn12_check (
  .clk            (clk),
  .rst            (rst),
  .push           (push),
  .full           (full),
  .pixel          (pixel),
  .empty          (empty),
  .pop            (pop),
  .result         (result),
  .write_enable   (write_enable),
  .register_index (register_index),
  .write_data     (write_data)
);

>>> tb/nv12_output_checker.sv
`timescale 1ns / 100ps
// Output checker for the BGRA to NV12 converter: tracks registers, predicts and compares results.
module nv12_output_checker import bn12_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic                   full,
  input  pixel_t                 pixel,
  input  logic                   empty,
  input  logic                   pop,
  input  result_t                result,
  input  logic                   write_enable,
  input  logic [REG_INDEX_W-1:0] register_index,
  input  logic [CFG_W-1:0]       write_data,
  output int                     pending,
  output int                     errors,
  output int                     checked,
  output int                     chroma_blocks
);

  localparam int LINE_ENTRIES = (MAX_WIDTH_DEFAULT + 1) / 2;

  // Shadow registers and converter state
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  int               col_pos;
  int               row_pos;
  logic [8:0]       held_u;
  logic [8:0]       held_v;
  logic [8:0]       line_u [LINE_ENTRIES];
  logic [8:0]       line_v [LINE_ENTRIES];
  result_t          expected_results [$];

  function automatic logic [7:0] clamp_byte(input int x);
    if (x < 0) return 8'd0;
    if (x > 255) return 8'd255;
    return 8'(x);
  endfunction

  // Per-pixel chroma term, biased so the shift works on a non-negative value
  function automatic int chroma_term(input int weighted);
    int biased;
    biased = weighted + 128 + 32768;
    return (biased < 0) ? 0 : (biased >>> 8);
  endfunction

  // Convert one pixel and advance the raster position
  function automatic result_t convert_pixel(input pixel_t px);
    int      r, g, b, u, v, w, h, idx;
    result_t res;
    r = int'(px.red);
    g = int'(px.green);
    b = int'(px.blue);
    w = (width_reg < MIN_SIZE) ? MIN_SIZE :
        (width_reg > MAX_WIDTH_DEFAULT) ? MAX_WIDTH_DEFAULT : int'(width_reg);
    h = (height_reg < MIN_SIZE) ? MIN_SIZE :
        (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
    res = '0;
    res.luma = clamp_byte(((66 * r + 129 * g + 25 * b + 128) >>> 8) + 16);
    u = chroma_term(-38 * r - 74 * g + 112 * b);
    v = chroma_term(112 * r - 94 * g - 18 * b);
    idx = col_pos >> 1;

    // Hold the left pixel, store the pair sum on even rows, average on odd rows
    if ((col_pos % 2) == 0) begin
      held_u = 9'(u);
      held_v = 9'(v);
    end else if ((row_pos % 2) == 0) begin
      line_u[idx] = 9'(int'(held_u) + u);
      line_v[idx] = 9'(int'(held_v) + v);
    end else begin
      res.chroma_valid = 1'b1;
      res.chroma_u = clamp_byte((int'(line_u[idx]) + int'(held_u) + u) >>> 2);
      res.chroma_v = clamp_byte((int'(line_v[idx]) + int'(held_v) + v) >>> 2);
    end

    // Wrap column, then row, at the effective frame size
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      if (row_pos + 1 >= h) begin
        row_pos = 0;
        res.frame_end = 1'b1;
      end else begin
        row_pos++;
      end
    end else begin
      col_pos++;
    end
    return res;
  endfunction

  task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  // Match accepted results against the oldest prediction, then log new pixels and writes
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      width_reg = FRAME_WIDTH_RESET;
      height_reg = FRAME_HEIGHT_RESET;
      col_pos = 0;
      row_pos = 0;
      held_u = '0;
      held_v = '0;
      expected_results.delete();
    end else begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $error("result with no pixel outstanding: %p", result);
          errors++;
        end else begin
          want = expected_results.pop_front();
          checked++;
          if (want.chroma_valid) chroma_blocks++;
          compare_field("luma", want.luma, result.luma);
          compare_field("chroma_valid", 8'(want.chroma_valid), 8'(result.chroma_valid));
          compare_field("chroma_u", want.chroma_u, result.chroma_u);
          compare_field("chroma_v", want.chroma_v, result.chroma_v);
          compare_field("frame_end", 8'(want.frame_end), 8'(result.frame_end));
        end
      end
      if (push && !full) begin
        expected_results.insert(expected_results.size(), convert_pixel(pixel));
      end
      if (write_enable) begin
        case (register_index)
          REG_FRAME_WIDTH:  width_reg = write_data;
          REG_FRAME_HEIGHT: height_reg = write_data;
          default: ;
        endcase
      end
    end
    pending = expected_results.size();
  end

endmodule

>>> tb/tb_bgra_to_nv12_converter.sv
`timescale 1ns / 100ps
// Testbench top for the BGRA to NV12 converter: stimulus, flow control, watchdog and verdict.
module tb_bgra_to_nv12_converter;
  import bn12_pkg::*;

  localparam int RANDOM_PIXELS  = 1225;
  localparam int STALL_LIMIT    = 2000;
  localparam int PRESSURE_AT    = 200;
  localparam int PRESSURE_HOLD  = 80;
  localparam int DRAIN_CYCLES   = 10;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   push;
  logic                   full;
  pixel_t                 pixel;
  logic                   empty;
  logic                   pop;
  result_t                result;
  logic                   write_enable;
  logic [REG_INDEX_W-1:0] register_index;
  logic [CFG_W-1:0]       write_data;

  int pending, errors, checked, chroma_blocks;
  int pixels_sent    = 0;
  int reg_writes     = 0;
  int send_idle_pct  = 9;
  int recv_idle_pct  = 79;
  int stall_cycles   = 0;

  bgra_to_nv12_converter i_dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .pixel(pixel),
    .empty(empty),
    .pop(pop),
    .result(result),
    .write_enable(write_enable),
    .register_index(register_index),
    .write_data(write_data)
  );

  nv12_output_checker i_checker (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .pixel(pixel),
    .empty(empty),
    .pop(pop),
    .result(result),
    .write_enable(write_enable),
    .register_index(register_index),
    .write_data(write_data),
    .pending(pending),
    .errors(errors),
    .checked(checked),
    .chroma_blocks(chroma_blocks)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // One corner of the color cube: bit 0 blue, bit 1 green, bit 2 red
  function automatic pixel_t corner(input int k);
    return pixel_t'{{8{k[0]}}, {8{k[1]}}, {8{k[2]}}};
  endfunction

  // Bias channels toward the extremes now and then
  function automatic logic [7:0] random_channel();
    if ($urandom_range(7) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(255));
  endfunction

  // Effective size of one frame dimension
  function automatic int clamp_size(input int val, input int max_val);
    return (val < MIN_SIZE) ? MIN_SIZE : (val > max_val) ? max_val : val;
  endfunction

  // Offer one pixel, with random idle cycles first, and hold it until accepted
  task automatic send_pixel(input pixel_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    pixel <= px;
    @(posedge clk);
    while (full) @(posedge clk);
    pixels_sent++;
  endtask

  // Drain all outstanding results, let the pipeline settle, then write one register
  task automatic write_reg(input logic [REG_INDEX_W-1:0] idx, input int val);
    push <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
    write_enable <= 1'b1;
    register_index <= idx;
    write_data <= CFG_W'(val);
    @(posedge clk);
    write_enable <= 1'b0;
    reg_writes++;
  endtask

  // Set the frame size and send whole frames of random pixels
  task automatic run_frame(input int w_val, input int h_val, input int frames);
    int eff_w, eff_h;
    eff_w = (w_val < MIN_SIZE) ? MIN_SIZE :
            (w_val > MAX_WIDTH_DEFAULT) ? MAX_WIDTH_DEFAULT : w_val;
    eff_h = (h_val < MIN_SIZE) ? MIN_SIZE : (h_val > MAX_HEIGHT) ? MAX_HEIGHT : h_val;
    write_reg(REG_FRAME_WIDTH, w_val);
    write_reg(REG_FRAME_HEIGHT, h_val);
    repeat (eff_w * eff_h * frames)
      send_pixel(pixel_t'{random_channel(), random_channel(), random_channel()});
  endtask

  // Drain side: random stalls plus one long hold-off that fills the block
  initial begin
    int popped = 0;
    int hold_left = 0;
    bit pressure_done = 1'b0;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (pop && !empty) popped++;
      if (popped >= PRESSURE_AT && !pressure_done) begin
        pressure_done = 1'b1;
        hold_left = PRESSURE_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("bgra_to_nv12_converter test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int first_frame[4] = '{0, 7, 1, 4};
    int random_base, regime, w_val, h_val, left, frame_px;
    rst <= 1'b1;
    push <= 1'b0;
    pixel <= '0;
    write_enable <= 1'b0;
    register_index <= REG_FRAME_WIDTH;
    write_data <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Smallest frame, cube corners
    write_reg(REG_FRAME_WIDTH, 2);
    write_reg(REG_FRAME_HEIGHT, 2);
    foreach (first_frame[i]) send_pixel(corner(first_frame[i]));

    // Odd last column and row get no chroma
    write_reg(REG_FRAME_WIDTH, 3);
    write_reg(REG_FRAME_HEIGHT, 3);
    for (int i = 0; i < 9; i++) send_pixel(corner((i * 5 + 2) % 8));

    // Shrink both sizes mid-frame at an even row start: the row count wraps past the height
    write_reg(REG_FRAME_WIDTH, 4);
    write_reg(REG_FRAME_HEIGHT, 6);
    for (int i = 0; i < 8; i++) send_pixel(corner(7 - i));
    write_reg(REG_FRAME_WIDTH, 2);
    write_reg(REG_FRAME_HEIGHT, 1);
    send_pixel(corner(3));
    send_pixel(corner(5));

    // Random frame sizes, mostly small; idling pattern changes by thirds
    random_base = pixels_sent;
    while (pixels_sent - random_base < RANDOM_PIXELS) begin
      left = RANDOM_PIXELS - (pixels_sent - random_base);
      regime = (pixels_sent - random_base) * 3 / RANDOM_PIXELS;
      send_idle_pct = (regime == 0) ? 9 : (regime == 1) ? 79 : 0;
      recv_idle_pct = (regime == 0) ? 79 : (regime == 1) ? 9 : 0;
      w_val = ($urandom_range(9) == 0) ? $urandom_range(80, 2) : $urandom_range(16, 2);
      if ($urandom_range(15) == 0) w_val = $urandom_range(1);
      h_val = $urandom_range(9, 2);
      if ($urandom_range(15) == 0) h_val = $urandom_range(1);
      // Fall back to the smallest frame near the end of the pixel budget
      frame_px = clamp_size(w_val, MAX_WIDTH_DEFAULT) * clamp_size(h_val, MAX_HEIGHT);
      if (frame_px > left) begin
        w_val = 2;
        h_val = 2;
        frame_px = 4;
      end
      run_frame(w_val, h_val, (2 * frame_px <= left) ? int'($urandom_range(2, 1)) : 1);
    end
    push <= 1'b0;

    // Wait for the last results, then give stray ones time to show up
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d pixels across %0d register writes: frames from 2x2 up to 80x9,",
             pixels_sent, reg_writes);
    $display("odd and clamped sizes, mid-frame size changes; %0d results, %0d with chroma.",
             checked, chroma_blocks);
    if (errors == 0 && pending == 0) begin
      $display("bgra_to_nv12_converter test passed");
    end else begin
      $display("bgra_to_nv12_converter test failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/bn12_pkg.sv
hw/rtl/bn12_ram.sv
hw/rtl/bn12_fifo.sv
hw/rtl/bn12_front.sv
hw/rtl/bn12_back.sv
hw/rtl/bgra_to_nv12_converter.sv
hw/rtl/bn12_check.sv
tb/nv12_output_checker.sv
tb/tb_bgra_to_nv12_converter.sv
